@@ hdl/snb_pkg.sv @@
// Shared constants and types for the signed network balance block.
// No dependencies; used by signed_network_balance_update and its testbench.
package snb_pkg;

    localparam int MAX_AGENTS = 64;
    localparam int ROW_W      = 64;
    localparam int ROW_AW     = $clog2(MAX_AGENTS);
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;

    localparam logic [CNT_W-1:0] RESET_SIZE = CNT_W'(MAX_AGENTS);

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DR_RD,
        S_DR_WAIT,
        S_UPD,
        S_CHK,
        S_DONE
    } t_state;

endpackage

@@ hdl/snb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module snb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/signed_network_balance_update.sv @@
// One sign matrix row read per cycle sets the pace of the row sweeps over the
// n = active agents (0..64). A load writes its row; an update reads the donor
// row and rewrites each active row. The check then sweeps the rows once against row 0.
// One word at a time: o_ready returns with o_valid, once the result is registered.
// Reset (sync, active low) clears control and sets the active size to 64.
module signed_network_balance_update (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_cmd,
    input  logic [snb_pkg::IDX_W-1:0]             i_row_index,
    input  logic [snb_pkg::ROW_W-1:0]             i_row_bits,
    input  logic [snb_pkg::IDX_W-1:0]             i_donor,
    input  logic [snb_pkg::IDX_W-1:0]             i_recipient,
    input  logic [snb_pkg::ROW_W-1:0]             i_flip_mask,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_balanced,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [snb_pkg::CNT_W-1:0]             i_cfg_active_size
);

    snb_pkg::t_state r_state, n_state;

    logic [snb_pkg::CNT_W-1:0]  r_active_size;
    logic                       r_cmd;
    logic [snb_pkg::IDX_W-1:0]  r_row_index;
    logic [snb_pkg::ROW_W-1:0]  r_row_bits;
    logic [snb_pkg::IDX_W-1:0]  r_donor;
    logic [snb_pkg::IDX_W-1:0]  r_recipient;
    logic [snb_pkg::ROW_W-1:0]  r_flip_mask;

    logic [snb_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic                       r_rd_vld;
    logic [snb_pkg::ROW_AW-1:0] r_rd_tag;
    logic                       r_dr;
    logic [snb_pkg::ROW_W-1:0]  r_row0;
    logic                       r_fail;
    logic                       r_out_valid;
    logic                       r_balanced;

    logic [snb_pkg::CNT_W-1:0]  w_n;
    logic [snb_pkg::ROW_W-1:0]  w_mask;
    logic                       w_accept;
    logic                       w_issue;
    logic                       w_sweep_done;
    logic                       w_upd_ok;
    logic                       w_load_ok;
    logic                       w_out_free;

    logic                       w_rd_sweep;
    logic [snb_pkg::ROW_AW-1:0] w_rd_addr;
    logic                       w_wr_en;
    logic [snb_pkg::ROW_AW-1:0] w_wr_addr;
    logic [snb_pkg::ROW_W-1:0]  w_wr_data;
    logic [snb_pkg::ROW_W-1:0]  w_rd_data;

    logic [snb_pkg::ROW_W-1:0]  w_ref;
    logic                       w_row_fail;
    logic [snb_pkg::ROW_W-1:0]  w_upd_row;

    snb_ram #(
        .WIDTH (snb_pkg::ROW_W),
        .DEPTH (snb_pkg::MAX_AGENTS)
    ) u_sign_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_n = (r_active_size > snb_pkg::CNT_W'(snb_pkg::MAX_AGENTS))
               ? snb_pkg::CNT_W'(snb_pkg::MAX_AGENTS) : r_active_size;

    always_comb begin
        for (int k = 0; k < snb_pkg::ROW_W; k++) begin
            w_mask[k] = (snb_pkg::CNT_W'(k) < w_n);
        end
    end

    assign o_ready      = (r_state == snb_pkg::S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign w_accept     = i_valid && o_ready;
    assign w_issue      = (r_idx < w_n);
    assign w_sweep_done = !w_issue && !r_rd_vld;
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_upd_ok     = ({1'b0, r_donor} < snb_pkg::CNT_W'(snb_pkg::MAX_AGENTS))
                       && ({1'b0, r_recipient} < snb_pkg::CNT_W'(snb_pkg::MAX_AGENTS))
                       && (w_n != '0);
    assign w_load_ok    = ({1'b0, r_row_index} < snb_pkg::CNT_W'(snb_pkg::MAX_AGENTS));

    assign w_ref      = (r_rd_tag == '0) ? w_rd_data : r_row0;
    assign w_row_fail = (((w_rd_data ^ w_ref ^ {snb_pkg::ROW_W{w_ref[r_rd_tag]}}) & w_mask)
                        != '0);

    always_comb begin
        w_upd_row          = w_rd_data;
        w_upd_row[r_donor] = w_rd_data[r_recipient] ^ r_dr ^ r_flip_mask[r_rd_tag];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            snb_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_cmd == snb_pkg::CMD_LOAD) ? snb_pkg::S_LOAD
                                                            : snb_pkg::S_DR_RD;
                end
            end
            snb_pkg::S_LOAD:    n_state = snb_pkg::S_CHK;
            snb_pkg::S_DR_RD:   n_state = w_upd_ok ? snb_pkg::S_DR_WAIT : snb_pkg::S_CHK;
            snb_pkg::S_DR_WAIT: n_state = snb_pkg::S_UPD;
            snb_pkg::S_UPD: begin
                if (w_sweep_done) begin
                    n_state = snb_pkg::S_CHK;
                end
            end
            snb_pkg::S_CHK: begin
                if (w_sweep_done) begin
                    n_state = snb_pkg::S_DONE;
                end
            end
            snb_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = snb_pkg::S_IDLE;
                end
            end
            default: n_state = snb_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        w_rd_sweep = 1'b0;
        w_rd_addr  = r_idx[snb_pkg::ROW_AW-1:0];
        w_wr_en    = 1'b0;
        w_wr_addr  = r_rd_tag;
        w_wr_data  = w_upd_row;
        n_idx      = r_idx;
        unique case (r_state)
            snb_pkg::S_LOAD: begin
                w_wr_en   = w_load_ok;
                w_wr_addr = r_row_index[snb_pkg::ROW_AW-1:0];
                w_wr_data = r_row_bits;
            end
            snb_pkg::S_DR_RD: begin
                w_rd_addr = r_donor[snb_pkg::ROW_AW-1:0];
            end
            snb_pkg::S_UPD: begin
                w_rd_sweep = w_issue;
                w_wr_en    = r_rd_vld;
                n_idx      = w_issue ? r_idx + 1'b1 : (w_sweep_done ? '0 : r_idx);
            end
            snb_pkg::S_CHK: begin
                w_rd_sweep = w_issue;
                n_idx      = w_issue ? r_idx + 1'b1 : r_idx;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= snb_pkg::S_IDLE;
            r_active_size <= snb_pkg::RESET_SIZE;
            r_idx         <= '0;
            r_rd_vld      <= 1'b0;
            r_fail        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rd_vld <= w_rd_sweep;
            if (i_cfg_valid) begin
                r_active_size <= i_cfg_active_size;
            end
            if (w_accept) begin
                r_fail <= 1'b0;
            end else if (r_state == snb_pkg::S_CHK && r_rd_vld && w_row_fail) begin
                r_fail <= 1'b1;
            end
            if (r_state == snb_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= i_cmd;
            r_row_index <= i_row_index;
            r_row_bits  <= i_row_bits;
            r_donor     <= i_donor;
            r_recipient <= i_recipient;
            r_flip_mask <= i_flip_mask;
        end
        r_rd_tag <= w_rd_addr;
        if (r_state == snb_pkg::S_DR_WAIT) begin
            r_dr <= w_rd_data[r_recipient];
        end
        if (r_state == snb_pkg::S_CHK && r_rd_vld && r_rd_tag == '0) begin
            r_row0 <= w_rd_data;
        end
        if (r_state == snb_pkg::S_DONE && w_out_free) begin
            r_balanced <= !r_fail;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_balanced = r_balanced;

    a_wr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == snb_pkg::S_LOAD || r_state == snb_pkg::S_UPD))
        else $error("matrix written outside load or update phase");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != snb_pkg::S_IDLE))
        else $error("accepted word did not start a sequence");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == snb_pkg::S_UPD || r_state == snb_pkg::S_CHK) |-> (r_idx <= w_n))
        else $error("row sweep ran past the active size");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == snb_pkg::S_DONE))
        else $error("result raised outside the done state");

    a_cmd_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == snb_pkg::S_LOAD) |-> (r_cmd == snb_pkg::CMD_LOAD))
        else $error("load phase entered for an update word");

endmodule

@@ test/tb_signed_network_balance_update.sv @@
// Self-checking bench for signed_network_balance_update: row loads and opinion updates
// checked against a shadow sign matrix under several active sizes and random stalls.
// Depends on snb_pkg and the signed_network_balance_update RTL.
module tb_signed_network_balance_update;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 2 * snb_pkg::MAX_AGENTS + 60;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_AT        = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int CALM_FROM      = 100;
    localparam int CALM_TO        = 170;

    typedef struct {
        bit                        is_cfg;
        logic [snb_pkg::CNT_W-1:0] size;
        logic                      cmd;
        logic [snb_pkg::IDX_W-1:0] row;
        logic [snb_pkg::ROW_W-1:0] bits;
        logic [snb_pkg::IDX_W-1:0] donor;
        logic [snb_pkg::IDX_W-1:0] recipient;
        logic [snb_pkg::ROW_W-1:0] flips;
    } t_net_step;

    logic                      i_clk;
    logic                      i_rst_n           = 1'b0;
    logic                      i_valid           = 1'b0;
    logic                      o_ready;
    logic                      i_cmd             = snb_pkg::CMD_LOAD;
    logic [snb_pkg::IDX_W-1:0] i_row_index       = '0;
    logic [snb_pkg::ROW_W-1:0] i_row_bits        = '0;
    logic [snb_pkg::IDX_W-1:0] i_donor           = '0;
    logic [snb_pkg::IDX_W-1:0] i_recipient       = '0;
    logic [snb_pkg::ROW_W-1:0] i_flip_mask       = '0;
    logic                      o_valid;
    logic                      i_ready           = 1'b0;
    logic                      o_balanced;
    logic                      i_cfg_valid       = 1'b0;
    logic                      o_cfg_ready;
    logic [snb_pkg::CNT_W-1:0] i_cfg_active_size = snb_pkg::RESET_SIZE;

    t_net_step                 net_steps[$];
    logic                      balance_due[$];
    logic [snb_pkg::ROW_W-1:0] shadow_rows [snb_pkg::MAX_AGENTS];
    logic [snb_pkg::CNT_W-1:0] shadow_agents = snb_pkg::RESET_SIZE;

    int  words_in    = 0;
    int  words_out   = 0;
    int  cfg_writes  = 0;
    int  words_sent  = 0;
    int  cfg_sent    = 0;
    int  settle      = 0;
    int  idle_cycles = 0;
    int  mismatches  = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    bit  stim_done   = 1'b0;

    signed_network_balance_update i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_row_index       (i_row_index),
        .i_row_bits        (i_row_bits),
        .i_donor           (i_donor),
        .i_recipient       (i_recipient),
        .i_flip_mask       (i_flip_mask),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_balanced        (o_balanced),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_active_size (i_cfg_active_size)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [snb_pkg::ROW_W-1:0] rand_row();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [snb_pkg::ROW_W-1:0] active_mask(int n);
        return (n >= snb_pkg::ROW_W) ? '1
             : ((snb_pkg::ROW_W'(1) << n) - snb_pkg::ROW_W'(1));
    endfunction

    function automatic int agents_in_play();
        return (shadow_agents > snb_pkg::MAX_AGENTS) ? snb_pkg::MAX_AGENTS
                                                     : int'(shadow_agents);
    endfunction

    function automatic logic net_is_balanced();
        int                        n;
        logic [snb_pkg::ROW_W-1:0] m;
        logic [snb_pkg::ROW_W-1:0] pair;
        n = agents_in_play();
        m = active_mask(n);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                pair = {snb_pkg::ROW_W{shadow_rows[i][j]}} ^ shadow_rows[i] ^ shadow_rows[j];
                if ((pair & m) != '0) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void apply_opinion_update(logic [snb_pkg::IDX_W-1:0] d,
                                                 logic [snb_pkg::IDX_W-1:0] r,
                                                 logic [snb_pkg::ROW_W-1:0] flips);
        int                        n;
        logic [snb_pkg::ROW_W-1:0] fresh;
        logic                      dr;
        n     = agents_in_play();
        fresh = '0;
        dr    = shadow_rows[d][r];
        for (int o = 0; o < n; o++) fresh[o] = shadow_rows[o][r] ^ dr ^ flips[o];
        for (int o = 0; o < n; o++) shadow_rows[o][d] = fresh[o];
    endfunction

    function automatic void queue_step(t_net_step s);
        net_steps.insert(net_steps.size(), s);
    endfunction

    function automatic void plan_size(int n);
        t_net_step s;
        s        = '{default: '0};
        s.is_cfg = 1'b1;
        s.size   = snb_pkg::CNT_W'(n);
        queue_step(s);
    endfunction

    function automatic void plan_load(logic [snb_pkg::IDX_W-1:0] row,
                                      logic [snb_pkg::ROW_W-1:0] bits);
        t_net_step s;
        s      = '{default: '0};
        s.cmd  = snb_pkg::CMD_LOAD;
        s.row  = row;
        s.bits = bits;
        s.donor = snb_pkg::IDX_W'($urandom);
        s.recipient = snb_pkg::IDX_W'($urandom);
        s.flips = rand_row();
        queue_step(s);
    endfunction

    function automatic void plan_update(logic [snb_pkg::IDX_W-1:0] d,
                                        logic [snb_pkg::IDX_W-1:0] r,
                                        logic [snb_pkg::ROW_W-1:0] flips);
        t_net_step s;
        s           = '{default: '0};
        s.cmd       = snb_pkg::CMD_UPDATE;
        s.row       = snb_pkg::IDX_W'($urandom);
        s.bits      = rand_row();
        s.donor     = d;
        s.recipient = r;
        s.flips     = flips;
        queue_step(s);
    endfunction

    // Rows i = v xor v[i] give a balanced network; bits n and above are noise.
    function automatic void plan_balanced_net(int n);
        logic [snb_pkg::ROW_W-1:0] v;
        logic [snb_pkg::ROW_W-1:0] m;
        v = rand_row();
        m = active_mask(n);
        for (int i = 0; i < n; i++)
            plan_load(snb_pkg::IDX_W'(i),
                      ((v ^ {snb_pkg::ROW_W{v[i]}}) & m) | (rand_row() & ~m));
    endfunction

    function automatic void plan_mixed(int n, int count);
        int                        roll;
        logic [snb_pkg::IDX_W-1:0] d;
        logic [snb_pkg::IDX_W-1:0] r;
        logic [snb_pkg::ROW_W-1:0] f;
        logic [snb_pkg::ROW_W-1:0] m;
        m = active_mask(n);
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
                d = snb_pkg::IDX_W'($urandom_range(n - 1));
                r = snb_pkg::IDX_W'($urandom_range(n - 1));
                if ($urandom_range(4) == 0) begin
                    d = snb_pkg::IDX_W'($urandom);
                    r = snb_pkg::IDX_W'($urandom);
                end
                case ($urandom_range(3))
                    0, 1: f = rand_row() & ~m;
                    2: f = (rand_row() & ~m) | (snb_pkg::ROW_W'(1) << $urandom_range(n - 1));
                    default: f = rand_row();
                endcase
                plan_update(d, r, f);
            end else if (n < snb_pkg::MAX_AGENTS) begin
                plan_load(snb_pkg::IDX_W'($urandom_range(snb_pkg::MAX_AGENTS - 1, n)),
                          rand_row());
            end else begin
                plan_load(snb_pkg::IDX_W'($urandom), rand_row());
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at result %0d: %s", words_out, what);
    endtask

    initial begin
        int sizes[5];
        sizes = '{2, 7, 13, 1, 3};

        plan_size(1);
        plan_balanced_net(snb_pkg::MAX_AGENTS);
        plan_size(snb_pkg::MAX_AGENTS);

        plan_update(6'd5, 6'd9, '0);
        plan_update(6'd17, 6'd17, '0);
        plan_update(6'd0, 6'd63, 64'h1);
        plan_update(6'd0, 6'd40, '0);
        plan_update(6'd63, 6'd0, '1);
        plan_update(6'd63, 6'd0, '0);
        plan_load(6'd63, '1);
        plan_load(6'd0, '0);
        plan_load(6'd0, '1);

        plan_size(3);
        plan_balanced_net(3);
        plan_update(6'd63, 6'd40, ~active_mask(3));
        plan_update(6'd1, 6'd2, ~active_mask(3));
        plan_load(6'd50, rand_row());

        plan_size(1);
        plan_load(6'd0, 64'h1);
        plan_load(6'd0, 64'hFFFF_FFFF_FFFF_FFFE);
        plan_update(6'd0, 6'd0, 64'h1);
        plan_update(6'd0, 6'd0, '0);

        plan_size(snb_pkg::MAX_AGENTS);
        plan_mixed(snb_pkg::MAX_AGENTS, 10);
        foreach (sizes[k]) begin
            plan_size(sizes[k]);
            plan_balanced_net(sizes[k]);
            plan_mixed(sizes[k], 4);
        end
        begin
            int n;
            n = $urandom_range(40, 4);
            plan_size(n);
            plan_mixed(n, 6);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (stim_done);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (balance_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", balance_due.size()));
        if (mismatches == 0)
            $display("signed_network_balance_update test passed");
        else
            $display("signed_network_balance_update test failed");
        $finish;
    end

    always @(negedge i_clk) begin : drive
        logic      valid_nx;
        logic      cfg_nx;
        bit        calm;
        t_net_step step;
        valid_nx = i_valid;
        cfg_nx   = i_cfg_valid;
        calm     = words_in >= CALM_FROM && words_in < CALM_TO;
        if (i_valid && words_in == words_sent) valid_nx = 1'b0;
        if (i_cfg_valid && cfg_writes == cfg_sent) cfg_nx = 1'b0;
        if (i_rst_n && !valid_nx && !cfg_nx && balance_due.size() == 0 &&
            words_out == words_sent)
            settle++;
        else
            settle = 0;
        if (i_rst_n && !valid_nx && !cfg_nx && net_steps.size() != 0) begin
            step = net_steps[0];
            if (step.is_cfg) begin
                if (settle >= SETTLE_CYCLES) begin
                    step = net_steps.pop_front();
                    i_cfg_active_size <= step.size;
                    cfg_nx = 1'b1;
                    cfg_sent++;
                    settle = 0;
                end
            end else if (calm || $urandom_range(99) >= 10) begin
                step = net_steps.pop_front();
                i_cmd       <= step.cmd;
                i_row_index <= step.row;
                i_row_bits  <= step.bits;
                i_donor     <= step.donor;
                i_recipient <= step.recipient;
                i_flip_mask <= step.flips;
                valid_nx = 1'b1;
                words_sent++;
            end
        end
        if (net_steps.size() == 0 && !valid_nx && !cfg_nx && balance_due.size() == 0 &&
            words_out == words_sent)
            stim_done = 1'b1;
        i_valid     <= valid_nx;
        i_cfg_valid <= cfg_nx;
    end

    // hold off once for a long stretch so the block backs up into its input
    always @(negedge i_clk) begin : receive
        bit calm;
        calm = words_out >= CALM_FROM && words_out < CALM_TO;
        if (!hold_done && words_out == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || $urandom_range(99) >= 10;
        end
    end

    always @(posedge i_clk) begin : watch
        logic want;
        bit   moved;
        if (!i_rst_n) begin
            shadow_agents = snb_pkg::RESET_SIZE;
            idle_cycles   = 0;
        end else begin
            moved = 1'b0;
            if (o_valid && i_ready) begin
                moved = 1'b1;
                if (balance_due.size() == 0) begin
                    report_mismatch("result with no word pending");
                end else begin
                    want = balance_due.pop_front();
                    if (o_balanced !== want)
                        report_mismatch($sformatf("balanced %b, expected %b", o_balanced, want));
                end
                words_out++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                shadow_agents = i_cfg_active_size;
                cfg_writes++;
            end
            if (i_valid && o_ready) begin
                moved = 1'b1;
                if (i_cmd == snb_pkg::CMD_LOAD)
                    shadow_rows[i_row_index] = i_row_bits;
                else
                    apply_opinion_update(i_donor, i_recipient, i_flip_mask);
                balance_due.insert(balance_due.size(), net_is_balanced());
                words_in++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("signed_network_balance_update test failed");
                $finish;
            end
        end
    end

endmodule
